>>> rtl/battery_can_frame_decoder_core_assert.svh
// Assertion macros used by the decoder core module.
`ifndef BATTERY_CAN_FRAME_DECODER_CORE_ASSERT_SVH
`define BATTERY_CAN_FRAME_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bcfd_pkg.sv
package bcfd_pkg;

    localparam int ID_W   = 29;
    localparam int LEN_W  = 4;
    localparam int PAY_W  = 64;
    localparam int CELL_W = 16;
    localparam int SUM_W  = 22;
    localparam int TEMP_W = 8;
    localparam int PCT_W  = 7;

    localparam logic [LEN_W-1:0] FRAME_LEN_OK = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_WRITE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        REG_CELL_BASE,
        REG_CELL_LAST,
        REG_TEMP_ID,
        REG_CHARGE_ID
    } cfg_reg_t;

    typedef struct packed {
        logic clear;
        logic take;
    } walk_ctrl_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

>>> rtl/bcfd_cell_mem.sv
module bcfd_cell_mem #(
    parameter int NUM_CELLS = 36,
    localparam int AW = $clog2(NUM_CELLS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcfd_pkg::mem_ctrl_t         ctrl,
    input  logic [AW-1:0]               waddr,
    input  logic [bcfd_pkg::CELL_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [bcfd_pkg::CELL_W-1:0] rd_data
);

    logic [bcfd_pkg::CELL_W-1:0] mem [NUM_CELLS];
    logic [NUM_CELLS-1:0]        valid_reg;
    logic [NUM_CELLS-1:0]        valid_next;
    logic [bcfd_pkg::CELL_W-1:0] rd_data_reg;
    logic                        rd_hit_reg;

    // A cell that was never written since reset reads as zero.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.re)
            begin
                rd_hit_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

>>> rtl/bcfd_walk.sv
module bcfd_walk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcfd_pkg::walk_ctrl_t        ctrl,
    input  logic [bcfd_pkg::CELL_W-1:0] value,
    output logic [bcfd_pkg::SUM_W-1:0]  sum,
    output logic [bcfd_pkg::CELL_W-1:0] low,
    output logic [bcfd_pkg::CELL_W-1:0] high
);

    logic [bcfd_pkg::SUM_W-1:0]  sum_reg;
    logic [bcfd_pkg::SUM_W-1:0]  sum_next;
    logic [bcfd_pkg::CELL_W-1:0] low_reg;
    logic [bcfd_pkg::CELL_W-1:0] low_next;
    logic [bcfd_pkg::CELL_W-1:0] high_reg;
    logic [bcfd_pkg::CELL_W-1:0] high_next;

    always_comb
    begin
        sum_next  = sum_reg;
        low_next  = low_reg;
        high_next = high_reg;
        if (ctrl.clear)
        begin
            sum_next  = '0;
            low_next  = '1;
            high_next = '0;
        end
        else if (ctrl.take)
        begin
            sum_next = sum_reg + bcfd_pkg::SUM_W'(value);
            if (value < low_reg)
            begin
                low_next = value;
            end
            if (value > high_reg)
            begin
                high_next = value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign sum  = sum_reg;
    assign low  = low_reg;
    assign high = high_reg;

endmodule

>>> rtl/battery_can_frame_decoder_core.sv
// Channel   Handshake                 Payload
// config    cfg_we                    cfg_index, cfg_data
// frames    in_valid / in_stall       frame_id, frame_len, payload
// results   out_valid / out_stall     handled, pack_mv ... charge_ok
//
// A cell frame passes through decode, a scan of the frame offsets, the cell writes, a
// walk over the cell memory and a drain; the walk sets the time between accepted frames.
// A misaligned cell identifier stops after the scan; other frames finish after decode.
// Reset clears the cell store through per-cell valid bits, so no clearing pass is needed.
// A new frame is taken only in the idle state; a result waits in the output register
// while out_stall is high, and the next frame may be accepted during that wait.
`include "battery_can_frame_decoder_core_assert.svh"

module battery_can_frame_decoder_core #(
    parameter int NUM_CELLS       = 36,
    parameter int CELLS_PER_FRAME = 4,
    parameter int ID_STEP         = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [bcfd_pkg::ID_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bcfd_pkg::ID_W-1:0]          frame_id,
    input  logic [bcfd_pkg::LEN_W-1:0]         frame_len,
    input  logic [bcfd_pkg::PAY_W-1:0]         payload,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               handled,
    output logic [bcfd_pkg::SUM_W-1:0]         pack_mv,
    output logic [bcfd_pkg::CELL_W-1:0]        min_cell_mv,
    output logic [bcfd_pkg::CELL_W-1:0]        max_cell_mv,
    output logic [bcfd_pkg::CELL_W-1:0]        spread_mv,
    output logic signed [bcfd_pkg::TEMP_W-1:0] temp_one,
    output logic signed [bcfd_pkg::TEMP_W-1:0] temp_two,
    output logic [bcfd_pkg::PCT_W-1:0]         charge_pct,
    output logic                               cells_ok,
    output logic                               temps_ok,
    output logic                               charge_ok
);

    localparam int FRAME_COUNT = (NUM_CELLS + CELLS_PER_FRAME - 1) / CELLS_PER_FRAME;
    localparam int AW  = $clog2(NUM_CELLS);
    localparam int CW  = $clog2(NUM_CELLS + CELLS_PER_FRAME);
    localparam int FW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int IW  = (CELLS_PER_FRAME > 1) ? $clog2(CELLS_PER_FRAME) : 1;
    localparam int IDW = bcfd_pkg::ID_W;
    localparam int CLW = bcfd_pkg::CELL_W;

    function automatic logic [bcfd_pkg::TEMP_W-1:0] temp_round(input logic [15:0] raw);
        logic [16:0] s;
        s = {1'b0, raw} + 17'd16;
        return s[12:5];
    endfunction

    // Percent is (200*b + 255) / 510; the quotient is x / 512 or one more.
    function automatic logic [bcfd_pkg::PCT_W-1:0] charge_round(input logic [7:0] b);
        logic [15:0] x;
        logic [6:0]  q0;
        logic [16:0] t;
        x  = 16'(16'(b) * 16'd200) + 16'd255;
        q0 = x[15:9];
        t  = 17'(17'(q0 + 7'd1) * 17'd510);
        return ({1'b0, x} >= t) ? q0 + 7'd1 : q0;
    endfunction

    bcfd_pkg::state_t state_reg, state_next;

    logic [IDW-1:0] cell_base_reg, cell_base_next;
    logic [IDW-1:0] cell_last_reg, cell_last_next;
    logic [IDW-1:0] temp_id_reg, temp_id_next;
    logic [IDW-1:0] charge_id_reg, charge_id_next;

    logic [IDW-1:0]                 id_reg;
    logic [bcfd_pkg::LEN_W-1:0]     len_reg;
    logic [bcfd_pkg::PAY_W-1:0]     payload_reg;

    logic [IDW-1:0] off_reg, off_next;
    logic [IDW-1:0] acc_reg, acc_next;
    logic [FW-1:0]  frame_cnt_reg, frame_cnt_next;
    logic [CW-1:0]  cell_addr_reg, cell_addr_next;
    logic [IW-1:0]  wr_cnt_reg, wr_cnt_next;
    logic [AW-1:0]  walk_cnt_reg, walk_cnt_next;
    logic           take_reg, take_next;

    logic [bcfd_pkg::TEMP_W-1:0] temp_a_reg, temp_a_next;
    logic [bcfd_pkg::TEMP_W-1:0] temp_b_reg, temp_b_next;
    logic [bcfd_pkg::PCT_W-1:0]  charge_reg, charge_next;
    logic cells_ok_reg, cells_ok_next;
    logic temps_ok_reg, temps_ok_next;
    logic charge_ok_reg, charge_ok_next;
    logic handled_reg, handled_next;

    logic out_valid_reg, out_valid_next;
    logic out_load;
    logic                         out_handled_reg;
    logic [bcfd_pkg::SUM_W-1:0]   out_pack_reg;
    logic [CLW-1:0]               out_min_reg;
    logic [CLW-1:0]               out_max_reg;
    logic [bcfd_pkg::TEMP_W-1:0]  out_temp_a_reg;
    logic [bcfd_pkg::TEMP_W-1:0]  out_temp_b_reg;
    logic [bcfd_pkg::PCT_W-1:0]   out_charge_reg;
    logic                         out_cells_ok_reg;
    logic                         out_temps_ok_reg;
    logic                         out_charge_ok_reg;

    bcfd_pkg::mem_ctrl_t  mem_ctrl;
    bcfd_pkg::walk_ctrl_t walk_ctrl;
    logic [AW-1:0]        mem_waddr;
    logic [CLW-1:0]       mem_wdata;
    logic [CLW-1:0]       mem_rd_data;
    logic [bcfd_pkg::SUM_W-1:0] walk_sum;
    logic [CLW-1:0]       walk_low;
    logic [CLW-1:0]       walk_high;

    logic in_accept;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != bcfd_pkg::ST_IDLE);

    always_comb
    begin
        cell_base_next = cell_base_reg;
        cell_last_next = cell_last_reg;
        temp_id_next   = temp_id_reg;
        charge_id_next = charge_id_reg;
        if (cfg_we)
        begin
            unique case (bcfd_pkg::cfg_reg_t'(cfg_index))
                bcfd_pkg::REG_CELL_BASE: cell_base_next = cfg_data;
                bcfd_pkg::REG_CELL_LAST: cell_last_next = cfg_data;
                bcfd_pkg::REG_TEMP_ID:   temp_id_next   = cfg_data;
                bcfd_pkg::REG_CHARGE_ID: charge_id_next = cfg_data;
                default:                 cell_base_next = cell_base_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        acc_next       = acc_reg;
        frame_cnt_next = frame_cnt_reg;
        cell_addr_next = cell_addr_reg;
        wr_cnt_next    = wr_cnt_reg;
        walk_cnt_next  = walk_cnt_reg;
        take_next      = 1'b0;
        temp_a_next    = temp_a_reg;
        temp_b_next    = temp_b_reg;
        charge_next    = charge_reg;
        cells_ok_next  = cells_ok_reg;
        temps_ok_next  = temps_ok_reg;
        charge_ok_next = charge_ok_reg;
        handled_next   = handled_reg;
        out_load       = 1'b0;
        mem_ctrl       = '0;
        walk_ctrl      = '0;
        mem_waddr      = cell_addr_reg[AW-1:0];
        mem_wdata      = payload_reg[wr_cnt_reg * CLW +: CLW];

        unique case (state_reg)
            bcfd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = bcfd_pkg::ST_DECODE;
                end
            end
            bcfd_pkg::ST_DECODE:
            begin
                handled_next = 1'b0;
                state_next   = bcfd_pkg::ST_FINISH;
                if (len_reg == bcfd_pkg::FRAME_LEN_OK)
                begin
                    if ((id_reg >= cell_base_reg) && (id_reg <= cell_last_reg))
                    begin
                        off_next       = id_reg - cell_base_reg;
                        acc_next       = '0;
                        frame_cnt_next = '0;
                        cell_addr_next = '0;
                        wr_cnt_next    = '0;
                        state_next     = bcfd_pkg::ST_SCAN;
                    end
                    else if (id_reg == temp_id_reg)
                    begin
                        temp_a_next   = temp_round(payload_reg[31:16]);
                        temp_b_next   = temp_round({payload_reg[39:32], payload_reg[47:40]});
                        temps_ok_next = 1'b1;
                        handled_next  = 1'b1;
                    end
                    else if ((id_reg == charge_id_reg) && (payload_reg[55:48] != 8'd0))
                    begin
                        charge_next    = charge_round(payload_reg[55:48]);
                        charge_ok_next = 1'b1;
                        handled_next   = 1'b1;
                    end
                end
            end
            bcfd_pkg::ST_SCAN:
            begin
                // The offset is compared against successive multiples of the step.
                if (off_reg == acc_reg)
                begin
                    state_next = bcfd_pkg::ST_WRITE;
                end
                else if (frame_cnt_reg == FW'(FRAME_COUNT - 1))
                begin
                    state_next = bcfd_pkg::ST_FINISH;
                end
                else
                begin
                    acc_next       = acc_reg + IDW'(ID_STEP);
                    frame_cnt_next = frame_cnt_reg + 1'b1;
                    cell_addr_next = cell_addr_reg + CW'(CELLS_PER_FRAME);
                end
            end
            bcfd_pkg::ST_WRITE:
            begin
                mem_ctrl.we    = (cell_addr_reg < CW'(NUM_CELLS));
                cell_addr_next = cell_addr_reg + 1'b1;
                wr_cnt_next    = wr_cnt_reg + 1'b1;
                if (wr_cnt_reg == IW'(CELLS_PER_FRAME - 1))
                begin
                    walk_ctrl.clear = 1'b1;
                    walk_cnt_next   = '0;
                    state_next      = bcfd_pkg::ST_WALK;
                end
            end
            bcfd_pkg::ST_WALK:
            begin
                mem_ctrl.re   = 1'b1;
                take_next     = 1'b1;
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == AW'(NUM_CELLS - 1))
                begin
                    state_next = bcfd_pkg::ST_DRAIN;
                end
            end
            bcfd_pkg::ST_DRAIN:
            begin
                cells_ok_next = 1'b1;
                handled_next  = 1'b1;
                state_next    = bcfd_pkg::ST_FINISH;
            end
            bcfd_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = bcfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcfd_pkg::ST_IDLE;
            end
        endcase

        walk_ctrl.take = take_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcfd_pkg::ST_IDLE;
            cell_base_reg <= '0;
            cell_last_reg <= '0;
            temp_id_reg   <= '0;
            charge_id_reg <= '0;
            off_reg       <= '0;
            acc_reg       <= '0;
            frame_cnt_reg <= '0;
            cell_addr_reg <= '0;
            wr_cnt_reg    <= '0;
            walk_cnt_reg  <= '0;
            take_reg      <= 1'b0;
            temp_a_reg    <= '0;
            temp_b_reg    <= '0;
            charge_reg    <= '0;
            cells_ok_reg  <= 1'b0;
            temps_ok_reg  <= 1'b0;
            charge_ok_reg <= 1'b0;
            handled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cell_base_reg <= cell_base_next;
            cell_last_reg <= cell_last_next;
            temp_id_reg   <= temp_id_next;
            charge_id_reg <= charge_id_next;
            off_reg       <= off_next;
            acc_reg       <= acc_next;
            frame_cnt_reg <= frame_cnt_next;
            cell_addr_reg <= cell_addr_next;
            wr_cnt_reg    <= wr_cnt_next;
            walk_cnt_reg  <= walk_cnt_next;
            take_reg      <= take_next;
            temp_a_reg    <= temp_a_next;
            temp_b_reg    <= temp_b_next;
            charge_reg    <= charge_next;
            cells_ok_reg  <= cells_ok_next;
            temps_ok_reg  <= temps_ok_next;
            charge_ok_reg <= charge_ok_next;
            handled_reg   <= handled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            id_reg      <= frame_id;
            len_reg     <= frame_len;
            payload_reg <= payload;
        end
        if (out_load)
        begin
            out_handled_reg   <= handled_reg;
            out_pack_reg      <= walk_sum;
            out_min_reg       <= walk_low;
            out_max_reg       <= walk_high;
            out_temp_a_reg    <= temp_a_reg;
            out_temp_b_reg    <= temp_b_reg;
            out_charge_reg    <= charge_reg;
            out_cells_ok_reg  <= cells_ok_reg;
            out_temps_ok_reg  <= temps_ok_reg;
            out_charge_ok_reg <= charge_ok_reg;
        end
    end

    bcfd_cell_mem #(
        .NUM_CELLS(NUM_CELLS)
    ) u_cell_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mem_ctrl),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr  (walk_cnt_reg),
        .rd_data(mem_rd_data)
    );

    bcfd_walk u_walk (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (walk_ctrl),
        .value(mem_rd_data),
        .sum  (walk_sum),
        .low  (walk_low),
        .high (walk_high)
    );

    assign out_valid   = out_valid_reg;
    assign handled     = out_handled_reg;
    assign pack_mv     = out_pack_reg;
    assign min_cell_mv = out_min_reg;
    assign max_cell_mv = out_max_reg;
    assign spread_mv   = out_max_reg - out_min_reg;
    assign temp_one    = out_temp_a_reg;
    assign temp_two    = out_temp_b_reg;
    assign charge_pct  = out_charge_reg;
    assign cells_ok    = out_cells_ok_reg;
    assign temps_ok    = out_temps_ok_reg;
    assign charge_ok   = out_charge_ok_reg;

    `BCFD_ASSERT_SAME(a_no_write_in_walk, state_reg == bcfd_pkg::ST_WALK, !mem_ctrl.we, "cell write during walk")
    `BCFD_ASSERT_SAME(a_take_follows_read, walk_ctrl.take, $past(state_reg) == bcfd_pkg::ST_WALK, "walk step without a read")
    `BCFD_ASSERT_NEXT(a_drain_marks_cells, state_reg == bcfd_pkg::ST_DRAIN, cells_ok_reg && handled_reg, "cell frame not marked")
    `BCFD_ASSERT_SAME(a_min_not_above_max, (state_reg == bcfd_pkg::ST_FINISH) && cells_ok_reg, walk_low <= walk_high, "lowest cell above highest cell")

endmodule
